// ----- hw/rtl/log_weight_softmax_normalizer_top_defines.svh -----
// assertion macros for the log-weight softmax normaliser
`ifndef LOG_WEIGHT_SOFTMAX_NORMALIZER_TOP_DEFINES_SVH
`define LOG_WEIGHT_SOFTMAX_NORMALIZER_TOP_DEFINES_SVH

// checked outside reset
`define LWSN_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define LWSN_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- hw/rtl/lwsn_pkg.sv -----
// types, constants and tables of the log-weight softmax normaliser
package lwsn_pkg;

   localparam int WEIGHT_W   = 24;
   localparam int PROB_W     = 17;
   localparam int DIFF_W     = 25;
   localparam int LSUM_W     = 16;
   localparam int SUM_W      = 24;
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CW    = 4;

   typedef struct packed {
      logic signed [WEIGHT_W-1:0] log_weight;
      logic                       last_in;
   } req_word_type;

   typedef struct packed {
      logic [PROB_W-1:0] probability;
      logic              overflowed;
      logic              last_out;
   } rsp_word_type;

   typedef struct packed {
      logic              valid;
      logic [DIFF_W-1:0] m;
      logic              last;
   } exp_in_type;

   typedef struct packed {
      logic              valid;
      logic [PROB_W-1:0] value;
      logic              last;
   } exp_out_type;

   typedef enum logic [3:0] {
      ST_COLLECT = 4'b0001,
      ST_SUM     = 4'b0010,
      ST_LN      = 4'b0100,
      ST_EMIT    = 4'b1000
   } state_type;

   // 2^(-i/16) in q16
   function automatic logic [16:0] pow2_neg_entry(input logic [4:0] i);
      logic [16:0] v;
      unique case (i)
         5'd0:  v = 17'd65536;
         5'd1:  v = 17'd62757;
         5'd2:  v = 17'd60097;
         5'd3:  v = 17'd57549;
         5'd4:  v = 17'd55109;
         5'd5:  v = 17'd52773;
         5'd6:  v = 17'd50535;
         5'd7:  v = 17'd48393;
         5'd8:  v = 17'd46341;
         5'd9:  v = 17'd44376;
         5'd10: v = 17'd42495;
         5'd11: v = 17'd40693;
         5'd12: v = 17'd38968;
         5'd13: v = 17'd37316;
         5'd14: v = 17'd35734;
         5'd15: v = 17'd34219;
         5'd16: v = 17'd32768;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   // log2(1 + i/16) in q16
   function automatic logic [16:0] log2_entry(input logic [4:0] i);
      logic [16:0] v;
      unique case (i)
         5'd0:  v = 17'd0;
         5'd1:  v = 17'd5732;
         5'd2:  v = 17'd11136;
         5'd3:  v = 17'd16248;
         5'd4:  v = 17'd21098;
         5'd5:  v = 17'd25711;
         5'd6:  v = 17'd30109;
         5'd7:  v = 17'd34312;
         5'd8:  v = 17'd38336;
         5'd9:  v = 17'd42196;
         5'd10: v = 17'd45904;
         5'd11: v = 17'd49472;
         5'd12: v = 17'd52911;
         5'd13: v = 17'd56229;
         5'd14: v = 17'd59434;
         5'd15: v = 17'd62534;
         5'd16: v = 17'd65536;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hw/rtl/lwsn_ram.sv -----
// generic single-write, single-read ram with registered read
module lwsn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output logic [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- hw/rtl/lwsn_exp.sv -----
// three-stage pipelined exp(-m) unit, q12 in, q16 out
module lwsn_exp (
   input  logic                clock,
   input  logic                reset,
   input  lwsn_pkg::exp_in_type  exp_in,
   output lwsn_pkg::exp_out_type exp_out
);
   logic [41:0] t_full;
   logic [29:0] t;

   logic        s1_v_ff;
   logic        s1_zero_ff;
   logic [4:0]  s1_k_ff;
   logic [15:0] s1_f_ff;
   logic        s1_last_ff;

   logic [16:0] tab_a;
   logic [16:0] tab_b;
   logic [16:0] tab_diff;

   logic        s2_v_ff;
   logic        s2_zero_ff;
   logic [4:0]  s2_k_ff;
   logic [16:0] s2_a_ff;
   logic [23:0] s2_prod_ff;
   logic        s2_last_ff;

   logic [24:0] interp;
   logic [16:0] r;
   logic [17:0] rnd;

   logic        out_v_ff;
   logic [16:0] out_value_ff;
   logic        out_last_ff;

   assign t_full   = 42'(exp_in.m) * 42'd94548 + 42'd2048;
   assign t        = t_full[41:12];
   assign tab_a    = lwsn_pkg::pow2_neg_entry({1'b0, s1_f_ff[15:12]});
   assign tab_b    = lwsn_pkg::pow2_neg_entry(5'({1'b0, s1_f_ff[15:12]}) + 5'd1);
   assign tab_diff = tab_a - tab_b;
   assign interp   = (25'(s2_prod_ff) + 25'd2048) >> 12;
   assign r        = s2_a_ff - interp[16:0];
   assign rnd      = 18'(r) + ((18'd1 << s2_k_ff) >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= exp_in.valid;
         s2_v_ff  <= s1_v_ff;
         out_v_ff <= s2_v_ff;
      end
      s1_zero_ff   <= t[29:16] >= 14'd17;
      s1_k_ff      <= t[20:16];
      s1_f_ff      <= t[15:0];
      s1_last_ff   <= exp_in.last;
      s2_zero_ff   <= s1_zero_ff;
      s2_k_ff      <= s1_k_ff;
      s2_a_ff      <= tab_a;
      s2_prod_ff   <= tab_diff[11:0] * s1_f_ff[11:0];
      s2_last_ff   <= s1_last_ff;
      out_value_ff <= s2_zero_ff ? 17'd0 : 17'(rnd >> s2_k_ff);
      out_last_ff  <= s2_last_ff;
   end

   assign exp_out.valid = out_v_ff;
   assign exp_out.value = out_value_ff;
   assign exp_out.last  = out_last_ff;
endmodule

// ----- hw/rtl/lwsn_ln.sv -----
// four-stage natural log unit, q16 in, q12 out
module lwsn_ln (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] sum,
   output logic        done,
   output logic [15:0] lsum
);
   logic [2:0]  pos;
   logic [23:0] norm;

   logic        v1_ff, v2_ff, v3_ff, v4_ff;
   logic        small1_ff, small2_ff, small3_ff;
   logic [2:0]  pos1_ff, pos2_ff;
   logic [15:0] g_ff;

   logic [16:0] tab_a;
   logic [16:0] tab_b;
   logic [16:0] tab_diff;
   logic [16:0] a_ff;
   logic [24:0] prod_ff;

   logic [25:0] interp;
   logic [19:0] l2_ff;
   logic [35:0] ln_full;
   logic [15:0] lsum_ff;

   always_comb begin
      pos = 3'd0;
      for (int i = 0; i < 8; i++) begin
         if (sum[16+i]) begin
            pos = 3'(i);
         end
      end
   end

   assign norm     = sum << (3'd7 - pos);
   assign tab_a    = lwsn_pkg::log2_entry({1'b0, g_ff[15:12]});
   assign tab_b    = lwsn_pkg::log2_entry(5'({1'b0, g_ff[15:12]}) + 5'd1);
   assign tab_diff = tab_b - tab_a;
   assign interp   = (26'(prod_ff) + 26'd2048) >> 12;
   assign ln_full  = 36'(l2_ff) * 36'd45426 + 36'd524288;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      small1_ff <= sum[23:16] == 8'd0;
      pos1_ff   <= pos;
      g_ff      <= norm[22:7];
      small2_ff <= small1_ff;
      pos2_ff   <= pos1_ff;
      a_ff      <= tab_a;
      prod_ff   <= tab_diff[12:0] * g_ff[11:0];
      small3_ff <= small2_ff;
      l2_ff     <= (20'(pos2_ff) << 16) + 20'(a_ff) + 20'(interp);
      lsum_ff   <= small3_ff ? 16'd0 : ln_full[35:20];
   end

   assign done = v4_ff;
   assign lsum = lsum_ff;
endmodule

// ----- hw/rtl/log_weight_softmax_normalizer_top.sv -----
// log-weight softmax normaliser: collection, sum, log and emit sequencer
//
// req channel: one log weight a word (signed q11.12), last_in closes the vector.
// rsp channel: one probability a word (unsigned q1.16) for each stored element,
// in arrival order, last_out on the final one, overflowed if elements were dropped.
// words beyond MAX_LEN are dropped; a dropped word with last_in still closes it.
// a valid word is taken whenever req_stall is low. after the closing word req_stall
// rises while the ram is read twice: once for the exp sum through the exp pipeline,
// then the log unit takes the log of the sum, then once more for the emit pass
// through the exp pipeline; both passes are bounded by the single ram read port.
// a stalled rsp word holds; up to 8 results queue in a register fifo and the ram
// read pass pauses while the fifo and the results in flight would fill it. reset
// clears all control state; the weight store needs no clearing and req is accepted
// at once.
`include "log_weight_softmax_normalizer_top_defines.svh"
module log_weight_softmax_normalizer_top #(
   parameter int MAX_LEN = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lwsn_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lwsn_pkg::rsp_word_type  rsp_word
);
   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   lwsn_pkg::state_type state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   logic signed [23:0]      max_ff, max_in;
   logic                    drop_ff, drop_in;
   logic [23:0]             sum_ff, sum_in;
   logic [15:0]             lsum_ff, lsum_in;
   logic [CW-1:0]           rd_idx_ff, rd_idx_in;
   logic [CW-1:0]           done_cnt_ff, done_cnt_in;
   logic                    rd_v_ff;
   logic                    rd_last_ff;
   logic [lwsn_pkg::FIFO_CW-1:0] inflight_ff, inflight_in;
   logic [lwsn_pkg::FIFO_CW-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic [lwsn_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lwsn_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [16:0]             fifo_prob_ff [lwsn_pkg::FIFO_DEPTH];
   logic                    fifo_last_ff [lwsn_pkg::FIFO_DEPTH];

   logic                    accept;
   logic                    store;
   logic                    credit;
   logic                    issue;
   logic                    push;
   logic                    pop;
   logic                    ln_start;
   logic                    ln_done;
   logic [15:0]             ln_lsum;
   logic [23:0]             rd_data;
   logic signed [24:0]      diff;
   lwsn_pkg::exp_in_type    exp_in;
   lwsn_pkg::exp_out_type   exp_out;

   assign req_stall = state_ff != lwsn_pkg::ST_COLLECT;
   assign accept    = req_valid && !req_stall;
   assign store     = accept && (count_ff < CW'(MAX_LEN));
   assign credit    = (5'(fifo_cnt_ff) + 5'(inflight_ff)) < 5'(lwsn_pkg::FIFO_DEPTH);
   assign issue     = (rd_idx_ff < count_ff) && ((state_ff == lwsn_pkg::ST_SUM) ||
                      ((state_ff == lwsn_pkg::ST_EMIT) && credit));
   assign ln_start  = (state_ff == lwsn_pkg::ST_SUM) && (done_cnt_ff == count_ff);
   assign push      = exp_out.valid && (state_ff == lwsn_pkg::ST_EMIT);
   assign rsp_valid = fifo_cnt_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;

   lwsn_ram #(
      .WIDTH (lwsn_pkg::WEIGHT_W),
      .DEPTH (MAX_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_word.log_weight),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   assign diff         = {max_ff[23], max_ff} - {rd_data[23], rd_data};
   assign exp_in.valid = rd_v_ff;
   assign exp_in.m     = $unsigned(diff) +
                         ((state_ff == lwsn_pkg::ST_EMIT) ? 25'(lsum_ff) : 25'd0);
   assign exp_in.last  = rd_last_ff;

   lwsn_exp u_exp (
      .clock   (clock),
      .reset   (reset),
      .exp_in  (exp_in),
      .exp_out (exp_out)
   );

   lwsn_ln u_ln (
      .clock (clock),
      .reset (reset),
      .start (ln_start),
      .sum   (sum_ff),
      .done  (ln_done),
      .lsum  (ln_lsum)
   );

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      max_in      = max_ff;
      drop_in     = drop_ff;
      sum_in      = sum_ff;
      lsum_in     = lsum_ff;
      rd_idx_in   = issue ? rd_idx_ff + CW'(1) : rd_idx_ff;
      done_cnt_in = done_cnt_ff;
      inflight_in = inflight_ff;
      unique case (state_ff)
         lwsn_pkg::ST_COLLECT: begin
            if (store) begin
               count_in = count_ff + CW'(1);
               if (req_word.log_weight > max_ff) begin
                  max_in = req_word.log_weight;
               end
            end else if (accept) begin
               drop_in = 1'b1;
            end
            if (accept && req_word.last_in) begin
               state_in    = lwsn_pkg::ST_SUM;
               rd_idx_in   = '0;
               done_cnt_in = '0;
               sum_in      = '0;
            end
         end
         lwsn_pkg::ST_SUM: begin
            if (exp_out.valid) begin
               sum_in      = sum_ff + 24'(exp_out.value);
               done_cnt_in = done_cnt_ff + CW'(1);
            end
            if (ln_start) begin
               state_in  = lwsn_pkg::ST_LN;
               rd_idx_in = '0;
            end
         end
         lwsn_pkg::ST_LN: begin
            if (ln_done) begin
               lsum_in  = ln_lsum;
               state_in = lwsn_pkg::ST_EMIT;
            end
         end
         lwsn_pkg::ST_EMIT: begin
            inflight_in = inflight_ff + (issue ? 4'd1 : 4'd0) - (push ? 4'd1 : 4'd0);
            if (pop && fifo_last_ff[rd_ptr_ff]) begin
               state_in = lwsn_pkg::ST_COLLECT;
               count_in = '0;
               max_in   = 24'sh800000;
               drop_in  = 1'b0;
               rd_idx_in = '0;
            end
         end
         default: state_in = lwsn_pkg::ST_COLLECT;
      endcase
      wr_ptr_in   = push ? wr_ptr_ff + 3'd1 : wr_ptr_ff;
      rd_ptr_in   = pop ? rd_ptr_ff + 3'd1 : rd_ptr_ff;
      fifo_cnt_in = fifo_cnt_ff + (push ? 4'd1 : 4'd0) - (pop ? 4'd1 : 4'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lwsn_pkg::ST_COLLECT;
         count_ff    <= '0;
         max_ff      <= 24'sh800000;
         drop_ff     <= 1'b0;
         sum_ff      <= '0;
         lsum_ff     <= '0;
         rd_idx_ff   <= '0;
         done_cnt_ff <= '0;
         rd_v_ff     <= 1'b0;
         inflight_ff <= '0;
         fifo_cnt_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         max_ff      <= max_in;
         drop_ff     <= drop_in;
         sum_ff      <= sum_in;
         lsum_ff     <= lsum_in;
         rd_idx_ff   <= rd_idx_in;
         done_cnt_ff <= done_cnt_in;
         rd_v_ff     <= issue;
         inflight_ff <= inflight_in;
         fifo_cnt_ff <= fifo_cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
      end
      rd_last_ff <= rd_idx_ff == (count_ff - CW'(1));
      if (push) begin
         fifo_prob_ff[wr_ptr_ff] <= exp_out.value;
         fifo_last_ff[wr_ptr_ff] <= exp_out.last;
      end
   end

   assign rsp_word.probability = fifo_prob_ff[rd_ptr_ff];
   assign rsp_word.overflowed  = drop_ff;
   assign rsp_word.last_out    = fifo_last_ff[rd_ptr_ff];

   `LWSN_CHECK(a_fifo_room, (5'(fifo_cnt_ff) + 5'(inflight_ff)) <= 5'(lwsn_pkg::FIFO_DEPTH), "result fifo overrun")
   `LWSN_CHECK(a_rsp_in_emit, rsp_valid |-> (state_ff == lwsn_pkg::ST_EMIT), "result outside emit pass")
   `LWSN_CHECK(a_count_bound, count_ff <= CW'(MAX_LEN), "element count past capacity")
   `LWSN_CHECK(a_close_to_sum, (accept && req_word.last_in) |=> (state_ff == lwsn_pkg::ST_SUM), "closing word did not start sum")
endmodule

// ----- sim/tb_log_weight_softmax_normalizer_top.sv -----
// testbench for the log-weight softmax normaliser: predicted probabilities against the rsp words
`timescale 1ns / 1ps
module tb_log_weight_softmax_normalizer_top;

   localparam int CAPACITY = 64;
   localparam logic signed [23:0] MOST_NEG = 24'sh800000;
   localparam logic signed [23:0] MOST_POS = 24'sh7FFFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   lwsn_pkg::req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   lwsn_pkg::rsp_word_type rsp_word;

   log_weight_softmax_normalizer_top #(.MAX_LEN(CAPACITY)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // predictor state
   logic signed [23:0] stored_weight [CAPACITY];
   int unsigned stored_count;
   logic signed [23:0] vector_max;
   bit dropped;
   lwsn_pkg::rsp_word_type expected_probs[$];

   bit failed = 1'b0;
   bit send_idle = 1'b0;
   bit recv_idle = 1'b0;
   int hold_cycles = 0;

   const logic [16:0] pow2_tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
      48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
   const logic [16:0] log2_tab [17] = '{0, 5732, 11136, 16248, 21098, 25711, 30109, 34312,
      38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536};

   function automatic logic [31:0] exp_of_neg(input longint unsigned m);
      longint unsigned t, k;
      int unsigned f, idx, frac, a, b, r;
      t = (m * 94548 + 2048) >> 12;
      k = t >> 16;
      if (k >= 17) return 0;
      f = 32'(t & 16'hFFFF);
      idx = f >> 12;
      frac = f & 12'hFFF;
      a = pow2_tab[idx];
      b = pow2_tab[idx + 1];
      r = a - (((a - b) * frac + 2048) >> 12);
      if (k == 0) return r;
      return (r + (1 << (k - 1))) >> k;
   endfunction

   function automatic logic [31:0] ln_of_sum(input int unsigned s);
      int unsigned p, g, idx, frac, a, b;
      longint unsigned mant, l2;
      if (s < 65536) return 0;
      p = 0;
      while (p < 31 && (s >> (p + 1)) != 0) p++;
      mant = (longint'(s) << (30 - p)) - (64'd1 << 30);
      g = 32'(mant >> 14);
      idx = g >> 12;
      frac = g & 12'hFFF;
      a = log2_tab[idx];
      b = log2_tab[idx + 1];
      l2 = (longint'(p - 16) << 16) + a + (((b - a) * frac + 2048) >> 12);
      return 32'((l2 * 45426 + (1 << 19)) >> 20);
   endfunction

   function automatic void predict_word(input lwsn_pkg::req_word_type w);
      longint unsigned sum, m;
      int unsigned lsum;
      lwsn_pkg::rsp_word_type r;
      sum = 0;
      if (stored_count < CAPACITY) begin
         stored_weight[stored_count] = w.log_weight;
         stored_count++;
         if (w.log_weight > vector_max) vector_max = w.log_weight;
      end else begin
         dropped = 1'b1;
      end
      if (!w.last_in) return;
      for (int i = 0; i < stored_count; i++)
         sum += exp_of_neg(longint'(vector_max) - longint'(stored_weight[i]));
      lsum = ln_of_sum(32'(sum & 24'hFFFFFF));
      for (int i = 0; i < stored_count; i++) begin
         m = longint'(vector_max) - longint'(stored_weight[i]) + lsum;
         r.probability = 17'(exp_of_neg(m));
         r.overflowed = dropped;
         r.last_out = (i + 1 == stored_count);
         expected_probs.push_back(r);
      end
      stored_count = 0;
      vector_max = MOST_NEG;
      dropped = 1'b0;
   endfunction

   task automatic send_word(input logic signed [23:0] lw, input bit last);
      while (send_idle) @(negedge clock);
      req_valid = 1'b1;
      req_word = '{log_weight: lw, last_in: last};
      do @(posedge clock); while (req_stall);
      predict_word('{log_weight: lw, last_in: last});
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (expected_probs.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [23:0] rand_weight();
      case ($urandom_range(0, 3))
         0: return 24'($urandom);
         1: return 24'(MOST_POS - $urandom_range(0, 20000));
         2: return 24'(MOST_NEG + $urandom_range(0, 20000));
         default: return 24'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   task automatic send_vector(input int len);
      logic signed [23:0] base;
      base = rand_weight();
      for (int i = 0; i < len; i++)
         send_word(($urandom_range(0, 1)) ? rand_weight() :
                   24'(base + $signed($urandom_range(0, 8191)) - 4096),
                   i == len - 1);
   endtask

   task automatic test_extremes();
      send_word(MOST_POS, 1'b1);
      send_word(MOST_NEG, 1'b1);
      send_word(MOST_POS, 1'b0);
      send_word(MOST_NEG, 1'b1);
      send_word(24'sd0, 1'b0);
      send_word(24'sd0, 1'b0);
      send_word(-24'sd4096, 1'b0);
      send_word(24'sd2839, 1'b1);
      send_word(24'sh555555, 1'b0);
      send_word(24'shAAAAAA, 1'b1);
   endtask

   task automatic test_overflow();
      send_vector(CAPACITY);
      for (int i = 0; i < CAPACITY + 2; i++) send_word(rand_weight(), 1'b0);
      send_word(rand_weight(), 1'b1);
      for (int i = 0; i < CAPACITY; i++) send_word(24'(-1000 * i), 1'b0);
      send_word(MOST_POS, 1'b1);
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_cycles = 300;
      for (int i = 0; i < 8; i++) send_vector($urandom_range(1, 6));
      wait_drained();
   endtask

   task automatic test_random(input int words);
      int sent;
      int len;
      sent = 0;
      while (sent < words) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 8);
         send_vector(len);
         sent += len;
      end
   endtask

   // random idling
   bit idling_on = 1'b1;
   initial begin
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            send_idle = 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            send_idle = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else if (recv_idle) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            recv_idle = 1'b1;
            repeat ($urandom_range(1, 14)) @(negedge clock);
            recv_idle = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      lwsn_pkg::rsp_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_probs.size() == 0) begin
            $error("unexpected word probability %0d", rsp_word.probability);
            failed = 1'b1;
         end else begin
            e = expected_probs.pop_front();
            if (rsp_word.probability !== e.probability) begin
               $error("probability expected %0d actual %0d", e.probability, rsp_word.probability);
               failed = 1'b1;
            end
            if (rsp_word.overflowed !== e.overflowed) begin
               $error("overflowed expected %0d actual %0d", e.overflowed, rsp_word.overflowed);
               failed = 1'b1;
            end
            if (rsp_word.last_out !== e.last_out) begin
               $error("last_out expected %0d actual %0d", e.last_out, rsp_word.last_out);
               failed = 1'b1;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("log_weight_softmax_normalizer_top verification failed");
      $finish;
   end

   initial begin
      stored_count = 0;
      vector_max = MOST_NEG;
      dropped = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_overflow();
      test_backpressure();
      test_random(230);
      wait_drained();
      idling_on = 1'b0;
      test_random(50);
      wait_drained();
      repeat (50) @(negedge clock);
      if (!failed && expected_probs.size() == 0)
         $display("log_weight_softmax_normalizer_top verification clean");
      else
         $display("log_weight_softmax_normalizer_top verification failed");
      $finish;
   end
endmodule
